// ===== hw/rtl/fsp_pkg.sv =====
// fsp_pkg: shared types and constants of the frame segment packetizer
// segment geometry, command and result records, status codes
// no dependencies
`timescale 1ns / 1ps

package fsp_pkg;

  // segment geometry
  localparam int HEAD_BYTES    = 64;
  localparam int BODY_BYTES    = 8192;
  localparam int BODY_SEGMENTS = 16;
  localparam int FRAME_BYTES   = HEAD_BYTES + BODY_SEGMENTS * BODY_BYTES;

  // byte position saturates at frame size + 1
  localparam int POS_W    = $clog2(FRAME_BYTES + 2);
  localparam int SEG_MAX  = (HEAD_BYTES > BODY_BYTES) ? HEAD_BYTES : BODY_BYTES;
  localparam int OFF_W    = $clog2(SEG_MAX);

  // module id sits in frame bytes 6 and 7
  localparam int ID_POS   = 7;
  localparam int EARLY_N  = 8;
  localparam int HDR_N    = 4;
  localparam int RESET_MAX_MODULE = 15;

  // result counts per command kind
  localparam int EARLY_RESULTS = HDR_N + EARLY_N;
  localparam int HDR_RESULTS   = HDR_N + 1;

  // queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // header byte order
  localparam logic [1:0] HB_MODULE = 2'd0;
  localparam logic [1:0] HB_FNUM_H = 2'd1;
  localparam logic [1:0] HB_FNUM_L = 2'd2;
  localparam logic [1:0] HB_SEG    = 2'd3;

  // frame status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LENGTH = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // one classified input byte, handed from front to back
  typedef struct packed {
    logic                   has_early;
    logic                   has_hdr;
    logic                   has_byte;
    logic                   has_status;
    logic [1:0]             code;
    logic                   de;
    logic [7:0]             data;
    logic [8*EARLY_N-1:0]   early;
    logic [7:0]             mod_id;
    logic [15:0]            fnum;
    logic [7:0]             seg;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic       dgram_end;
    logic [1:0] code;
    logic       run_last;
  } result_t;

endpackage

// ===== hw/rtl/fsp_front.sv =====
// fsp_front: accepts frame bytes, tracks frame position and module id,
// and turns accepted bytes into commands for the back end, at most one per byte
// depends on fsp_pkg
`timescale 1ns / 1ps

module fsp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    frame_byte,
  input  logic          frame_end,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data,
  input  logic          cmdq_full,
  output logic          cmd_push,
  output fsp_pkg::cmd_t cmd
);

  logic [fsp_pkg::POS_W-1:0] byte_position;
  logic [fsp_pkg::OFF_W-1:0] seg_off;
  logic [7:0]                segment_number;
  logic [15:0]               frame_number;
  logic [7:0]                current_module;
  logic                      dropping;
  logic [7:0]                max_module;
  logic [7:0]                early_bytes [fsp_pkg::ID_POS];

  logic                      accept;
  logic                      in_head;
  logic                      in_frame;
  logic                      at_id;
  logic                      past_id;
  logic                      seg_last;
  logic                      body_start;
  logic [15:0]               id;
  logic                      id_bad;
  logic                      drop_now;
  logic                      emit_early;
  logic                      emit_body;
  logic [7:0]                seg_inc;
  logic [1:0]                code;

  assign full      = cmdq_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !cmdq_full;

  // position classification
  assign in_head  = byte_position < fsp_pkg::POS_W'(fsp_pkg::HEAD_BYTES);
  assign in_frame = byte_position < fsp_pkg::POS_W'(fsp_pkg::FRAME_BYTES);
  assign at_id    = byte_position == fsp_pkg::POS_W'(fsp_pkg::ID_POS);
  assign past_id  = byte_position > fsp_pkg::POS_W'(fsp_pkg::ID_POS);
  assign seg_last = in_head ? (seg_off == fsp_pkg::OFF_W'(fsp_pkg::HEAD_BYTES - 1))
                            : (seg_off == fsp_pkg::OFF_W'(fsp_pkg::BODY_BYTES - 1));
  assign body_start = !in_head && in_frame && (seg_off == '0);
  assign seg_inc    = segment_number + 8'd1;

  // module id check
  assign id       = {early_bytes[fsp_pkg::ID_POS-1], frame_byte};
  assign id_bad   = id > {8'h00, max_module};
  assign drop_now = dropping || (at_id && id_bad);

  assign emit_early = !dropping && at_id && !id_bad;
  assign emit_body  = !dropping && past_id && in_frame;

  // frame status
  always_comb begin
    if (drop_now) begin
      code = fsp_pkg::ST_RANGE;
    end else if (byte_position != fsp_pkg::POS_W'(fsp_pkg::FRAME_BYTES - 1)) begin
      code = fsp_pkg::ST_LENGTH;
    end else begin
      code = fsp_pkg::ST_OK;
    end
  end

  // command build
  always_comb begin
    cmd.has_early  = emit_early;
    cmd.has_hdr    = emit_body && body_start;
    cmd.has_byte   = emit_body;
    cmd.has_status = frame_end;
    cmd.code       = code;
    cmd.de         = seg_last || frame_end;
    cmd.data       = frame_byte;
    cmd.early      = {frame_byte, early_bytes[6], early_bytes[5], early_bytes[4],
                      early_bytes[3], early_bytes[2], early_bytes[1], early_bytes[0]};
    cmd.mod_id     = emit_early ? id[7:0] : current_module;
    cmd.fnum       = frame_number;
    cmd.seg        = emit_early ? 8'd0 : (body_start ? seg_inc : segment_number);
  end

  assign cmd_push = accept && (emit_early || emit_body || frame_end);

  // first bytes held until the id is known
  always_ff @(posedge clk) begin
    if (accept && !dropping && (byte_position < fsp_pkg::POS_W'(fsp_pkg::ID_POS))) begin
      early_bytes[byte_position[2:0]] <= frame_byte;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_module <= 8'(fsp_pkg::RESET_MAX_MODULE);
    end else if (cfg_valid && cfg_ready) begin
      max_module <= cfg_data;
    end
  end

  // frame tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      seg_off        <= '0;
      segment_number <= '0;
      frame_number   <= '0;
      current_module <= '0;
      dropping       <= 1'b0;
    end else if (accept) begin
      if (emit_early) begin
        current_module <= id[7:0];
      end
      if (frame_end) begin
        byte_position  <= '0;
        seg_off        <= '0;
        segment_number <= '0;
        dropping       <= 1'b0;
        if (!drop_now && (at_id || past_id)) begin
          frame_number <= frame_number + 16'd1;
        end
      end else begin
        if (byte_position <= fsp_pkg::POS_W'(fsp_pkg::FRAME_BYTES)) begin
          byte_position <= byte_position + fsp_pkg::POS_W'(1);
        end
        if (in_frame) begin
          seg_off <= seg_last ? '0 : seg_off + fsp_pkg::OFF_W'(1);
        end
        if (emit_early) begin
          segment_number <= 8'd0;
        end else if (body_start) begin
          segment_number <= seg_inc;
        end
        if (drop_now) begin
          dropping <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fsp_cmd_queue.sv =====
// fsp_cmd_queue: short command queue between front and back end
// depends on fsp_pkg
`timescale 1ns / 1ps

module fsp_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  fsp_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output fsp_pkg::cmd_t rd_cmd,
  output logic          q_empty
);

  fsp_pkg::cmd_t               entries [fsp_pkg::CMDQ_DEPTH];
  logic [fsp_pkg::CMDQ_AW-1:0] wr_ptr;
  logic [fsp_pkg::CMDQ_AW-1:0] rd_ptr;
  logic [fsp_pkg::CMDQ_AW:0]   count;
  logic                        do_wr;
  logic                        do_rd;

  assign q_full  = count == (fsp_pkg::CMDQ_AW+1)'(fsp_pkg::CMDQ_DEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + fsp_pkg::CMDQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + fsp_pkg::CMDQ_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (fsp_pkg::CMDQ_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (fsp_pkg::CMDQ_AW+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/fsp_back.sv =====
// fsp_back: expands each command into header, payload and status results
// and holds them in a small output queue
// depends on fsp_pkg
`timescale 1ns / 1ps

module fsp_back (
  input  logic          clk,
  input  logic          rst,
  input  fsp_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          is_status,
  output logic          dgram_end,
  output logic [1:0]    status_code,
  output logic          run_last
);

  logic [3:0]                  step;
  logic [3:0]                  total;
  logic                        last;
  logic                        produce;
  logic                        hdr_phase;
  logic                        early_phase;
  logic                        byte_phase;
  logic [3:0]                  early_off;
  logic [2:0]                  early_idx;
  logic [7:0]                  hdr_byte;
  fsp_pkg::result_t            res;

  fsp_pkg::result_t            oq [fsp_pkg::OUTQ_DEPTH];
  logic [fsp_pkg::OUTQ_AW-1:0] oq_wptr;
  logic [fsp_pkg::OUTQ_AW-1:0] oq_rptr;
  logic [fsp_pkg::OUTQ_AW:0]   oq_count;
  logic                        oq_room;
  logic                        oq_pop;

  // number of results for this command
  always_comb begin
    if (cmd.has_early) begin
      total = 4'(fsp_pkg::EARLY_RESULTS);
    end else if (cmd.has_hdr) begin
      total = 4'(fsp_pkg::HDR_RESULTS);
    end else if (cmd.has_byte) begin
      total = 4'd1;
    end else begin
      total = 4'd0;
    end
    total = total + 4'(cmd.has_status);
  end

  assign last    = step == (total - 4'd1);
  assign oq_room = oq_count != (fsp_pkg::OUTQ_AW+1)'(fsp_pkg::OUTQ_DEPTH);
  assign produce = !cmd_empty && oq_room;
  assign cmd_pop = produce && last;

  // phase decode
  assign hdr_phase   = (cmd.has_early || cmd.has_hdr) && (step < 4'(fsp_pkg::HDR_N));
  assign early_phase = cmd.has_early && !hdr_phase
                       && (step < 4'(fsp_pkg::EARLY_RESULTS));
  assign byte_phase  = cmd.has_byte && (cmd.has_hdr ? (step == 4'(fsp_pkg::HDR_N))
                                                    : (step == 4'd0));
  assign early_off   = step - 4'(fsp_pkg::HDR_N);
  assign early_idx   = early_off[2:0];

  // header byte select
  always_comb begin
    case (step[1:0])
      fsp_pkg::HB_MODULE: hdr_byte = cmd.mod_id;
      fsp_pkg::HB_FNUM_H: hdr_byte = cmd.fnum[15:8];
      fsp_pkg::HB_FNUM_L: hdr_byte = cmd.fnum[7:0];
      fsp_pkg::HB_SEG:    hdr_byte = cmd.seg;
      default:            hdr_byte = cmd.seg;
    endcase
  end

  // result of the current step
  always_comb begin
    res.data      = 8'd0;
    res.is_status = 1'b0;
    res.dgram_end = 1'b0;
    res.code      = fsp_pkg::ST_OK;
    res.run_last  = last;
    if (hdr_phase) begin
      res.data = hdr_byte;
    end else if (early_phase) begin
      res.data      = cmd.early[8*early_idx +: 8];
      res.dgram_end = cmd.de && (step == 4'(fsp_pkg::EARLY_RESULTS - 1));
    end else if (byte_phase) begin
      res.data      = cmd.data;
      res.dgram_end = cmd.de;
    end else begin
      res.is_status = 1'b1;
      res.code      = cmd.code;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (produce) begin
      step <= last ? 4'd0 : step + 4'd1;
    end
  end

  // output queue
  assign empty       = oq_count == '0;
  assign oq_pop      = pop && !empty;
  assign out_byte    = oq[oq_rptr].data;
  assign is_status   = oq[oq_rptr].is_status;
  assign dgram_end   = oq[oq_rptr].dgram_end;
  assign status_code = oq[oq_rptr].code;
  assign run_last    = oq[oq_rptr].run_last;

  always_ff @(posedge clk) begin
    if (produce) begin
      oq[oq_wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (produce) begin
        oq_wptr <= oq_wptr + fsp_pkg::OUTQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rptr <= oq_rptr + fsp_pkg::OUTQ_AW'(1);
      end
      if (produce && !oq_pop) begin
        oq_count <= oq_count + (fsp_pkg::OUTQ_AW+1)'(1);
      end else if (oq_pop && !produce) begin
        oq_count <= oq_count - (fsp_pkg::OUTQ_AW+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/frame_segment_packetizer.sv =====
// frame_segment_packetizer: top level of the frame packetizer
// depends on fsp_pkg, fsp_front, fsp_cmd_queue, fsp_back
`timescale 1ns / 1ps

// Usage
// Frame bytes enter on a queue-style port: a transfer happens when push is
// high and full is low; frame_end marks the last byte of a frame. Results
// leave on a queue-style port: the oldest result is shown while empty is low
// and is taken when pop is high. Each result is a datagram byte (4-byte
// header of module id, frame number high, frame number low, segment number,
// then payload) or a frame status at the end of every frame.
// max_module is written on the cfg channel, cfg_ready is always high;
// the user must write it only while the block is idle; it is not enforced.
// The first result of a byte is registered in the command queue, then in
// the output queue. Throughput: one result per cycle out of the back end
// sequencer while the output queue has room; a plain payload byte gives one
// result, a segment start five, byte 7 of a frame twelve, and a frame end
// one more for the status. Input: one byte per cycle while full is low.
// A 4-entry command queue decouples the input from the sequencer, so a
// stalled receiver fills the queues and then raises full.
// Reset clears positions, frame number and queues; max_module returns to 15.

module frame_segment_packetizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       is_status,
  output logic       dgram_end,
  output logic [1:0] status_code,
  output logic       run_last
);

  fsp_pkg::cmd_t front_cmd;
  fsp_pkg::cmd_t head_cmd;
  logic          cmd_push;
  logic          cmdq_full;
  logic          cmdq_empty;
  logic          cmd_pop;

  // input classification
  fsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmdq_full  (cmdq_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  // decoupling queue
  fsp_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (front_cmd),
    .q_full  (cmdq_full),
    .rd_en   (cmd_pop),
    .rd_cmd  (head_cmd),
    .q_empty (cmdq_empty)
  );

  // result sequencing
  fsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .cmd_empty   (cmdq_empty),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .is_status   (is_status),
    .dgram_end   (dgram_end),
    .status_code (status_code),
    .run_last    (run_last)
  );

endmodule
